// ----- design/pidpi_pkg.sv -----
// Package for the PID controller block: field widths, register indexes,
// controller mode codes and the sequencer state type.
// No dependencies; used by every module of the block.
package pidpi_pkg;

    // Field and state widths
    localparam int DATA_W        = 16;   // target, measured, drive, limits
    localparam int GAIN_W        = 16;   // unsigned gains
    localparam int ERR_W         = DATA_W + 1;
    localparam int HIST_W        = 32;   // integral / error two samples back
    localparam int FRAC_BITS_DEF = 8;

    // Operand widths of the three serial multipliers
    localparam int P_OP_W = ERR_W + 1;   // e or e - e1
    localparam int I_OP_W = HIST_W;      // integral or e
    localparam int D_OP_W = HIST_W + 1;  // e - e1 or e - 2*e1 + e2

    // Width of the raw controller sum: largest product plus headroom
    localparam int SUM_W = D_OP_W + GAIN_W + 2;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW  = CFG_IDX_W'(5);

    // Controller forms
    localparam logic MODE_POS = 1'b0;
    localparam logic MODE_INC = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INT,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_CLAMP
    } state_t;

endpackage

// ----- design/pidpi_ser_mul.sv -----
// Serial shift-and-add multiplier: signed operand times unsigned gain,
// one gain bit per cycle, narrow adder over the operand width only.
// Depends on pidpi_pkg.
module pidpi_ser_mul #(
    parameter int A_W = pidpi_pkg::P_OP_W
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic signed [A_W-1:0]                       a,
    input  logic        [pidpi_pkg::GAIN_W-1:0]         b,
    output logic                                        busy,
    output logic signed [A_W+pidpi_pkg::GAIN_W-1:0]     product
);

    localparam int B_W   = pidpi_pkg::GAIN_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic signed [A_W-1:0] a_reg;
    logic signed [A_W:0]   hi_reg;
    logic signed [A_W:0]   hi_next;
    logic signed [A_W:0]   addend;
    logic signed [A_W:0]   part_sum;
    logic [B_W-1:0]        lo_reg;
    logic [B_W-1:0]        lo_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;

    // Add the operand when the current gain bit is set, then shift right
    always_comb
    begin
        addend   = lo_reg[0] ? {a_reg[A_W-1], a_reg} : '0;
        part_sum = hi_reg + addend;
        hi_next  = {part_sum[A_W], part_sum[A_W:1]};
        lo_next  = {part_sum[0], lo_reg[B_W-1:1]};
        if (start)
        begin
            cnt_next = CNT_W'(B_W);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Load operands on start, advance one gain bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            hi_reg <= '0;
            lo_reg <= b;
        end
        else if (busy)
        begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign busy    = (cnt_reg != '0);
    assign product = {hi_reg[A_W-1:0], lo_reg};

endmodule

// ----- design/pidpi_ser_div.sv -----
// Restoring divider, one quotient bit per cycle: unsigned dividend over
// an unsigned gain-wide divisor. Depends on pidpi_pkg.
module pidpi_ser_div #(
    parameter int DVD_W = pidpi_pkg::DATA_W + pidpi_pkg::FRAC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [DVD_W-1:0]               dividend,
    input  logic [pidpi_pkg::GAIN_W-1:0]   divisor,
    output logic                           busy,
    output logic [DVD_W-1:0]               quotient
);

    localparam int DSR_W = pidpi_pkg::GAIN_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg;
    logic [DVD_W-1:0] quo_next;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] rem_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W:0]   shifted;
    logic [DSR_W+1:0] diff;
    logic             fits;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // Trial subtract of the divisor from the shifted partial remainder
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        diff     = {1'b0, shifted} - {2'b00, dsr_reg};
        fits     = ~diff[DSR_W+1];
        rem_next = fits ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], fits};
        if (start)
        begin
            cnt_next = CNT_W'(DVD_W);
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Load on start, then shift dividend bits out and quotient bits in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

// ----- design/pid_positional_incremental_top.sv -----
// Top level of the PID controller: configuration registers, sequencer,
// controller state, result clamp and output register.
// Depends on pidpi_pkg, pidpi_ser_mul and pidpi_ser_div.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall   target, measured
//   output   out        out_valid / out_stall drive, clamped
//   config   in         cfg_we                cfg_index, cfg_data
//
// One item at a time. The incremental form goes straight to the multipliers;
// the positional form first updates the integral, and with a nonzero integral
// gain first runs the integral limit divider. The serial multipliers take 16
// steps and the integral limit divider takes (16+FRAC_BITS) steps.
// A result waiting under out_stall holds the next result in the clamp
// stage, and the block then takes no new transaction until it moves.
// Reset clears the controller state and loads the register defaults.
module pid_positional_incremental_top #(
    parameter int FRAC_BITS = pidpi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [pidpi_pkg::DATA_W-1:0]    target,
    input  logic signed [pidpi_pkg::DATA_W-1:0]    measured,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [pidpi_pkg::DATA_W-1:0]    drive,
    output logic                                   clamped,
    input  logic                                   cfg_we,
    input  logic [pidpi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidpi_pkg::DATA_W-1:0]           cfg_data
);

    localparam int DATA_W = pidpi_pkg::DATA_W;
    localparam int GAIN_W = pidpi_pkg::GAIN_W;
    localparam int ERR_W  = pidpi_pkg::ERR_W;
    localparam int HIST_W = pidpi_pkg::HIST_W;
    localparam int P_OP_W = pidpi_pkg::P_OP_W;
    localparam int I_OP_W = pidpi_pkg::I_OP_W;
    localparam int D_OP_W = pidpi_pkg::D_OP_W;
    localparam int SUM_W  = pidpi_pkg::SUM_W;
    localparam int ACC_W  = DATA_W + FRAC_BITS;
    localparam int DVD_W  = DATA_W + FRAC_BITS;
    localparam int LMT_W  = DVD_W + 1;
    localparam int CMP_W  = ((LMT_W > HIST_W + 1) ? LMT_W : HIST_W + 1) + 1;
    localparam logic [1:0] ADD_LAST = 2'd2;

    localparam logic signed [CMP_W-1:0] I32_MAX =
        {{(CMP_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
    localparam logic signed [CMP_W-1:0] I32_MIN =
        {{(CMP_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};

    // Configuration registers
    logic                       mode_reg;
    logic [GAIN_W-1:0]          gain_p_reg;
    logic [GAIN_W-1:0]          gain_i_reg;
    logic [GAIN_W-1:0]          gain_d_reg;
    logic signed [DATA_W-1:0]   limit_high_reg;
    logic signed [DATA_W-1:0]   limit_low_reg;

    // Sequencer
    pidpi_pkg::state_t state_reg;
    pidpi_pkg::state_t state_next;

    // Controller state and working registers
    logic signed [ERR_W-1:0]    e_reg;
    logic signed [ERR_W-1:0]    last_error_reg;
    logic signed [HIST_W-1:0]   hist_reg;
    logic signed [ACC_W-1:0]    accum_reg;
    logic signed [CMP_W-1:0]    isum_reg;
    logic signed [CMP_W-1:0]    lmt_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [1:0]                 add_cnt_reg;
    logic                       out_valid_reg;
    logic signed [DATA_W-1:0]   drive_reg;
    logic                       clamped_reg;

    // Sequencer outputs
    logic take_item;
    logic div_start;
    logic div_track;
    logic int_load;
    logic mul_start;
    logic sum_init;
    logic sum_step;
    logic result_load;

    // Datapath signals
    logic                       out_free;
    logic                       pos_int;
    logic signed [ERR_W-1:0]    e_in;
    logic signed [DATA_W:0]     span;
    logic signed [DATA_W:0]     span_mag;
    logic                       span_neg;
    logic [DVD_W-1:0]           dividend;
    logic [DVD_W-1:0]           quotient;
    logic                       div_busy;
    logic signed [CMP_W-1:0]    q_ext;
    logic signed [CMP_W-1:0]    nlmt;
    logic signed [CMP_W-1:0]    clip;
    logic signed [HIST_W-1:0]   integ_new;
    logic signed [P_OP_W-1:0]   diff_el;
    logic signed [P_OP_W-1:0]   p_op;
    logic signed [I_OP_W-1:0]   i_op;
    logic signed [D_OP_W-1:0]   d_op;
    logic signed [D_OP_W-1:0]   d_inc;
    logic signed [P_OP_W+GAIN_W-1:0] p_prod;
    logic signed [I_OP_W+GAIN_W-1:0] i_prod;
    logic signed [D_OP_W+GAIN_W-1:0] d_prod;
    logic                       p_busy;
    logic                       i_busy;
    logic                       d_busy;
    logic                       mul_busy;
    logic signed [SUM_W-1:0]    add_term;
    logic signed [SUM_W-1:0]    sum_base;
    logic signed [ACC_W-1:0]    hi_s;
    logic signed [ACC_W-1:0]    lo_s;
    logic signed [SUM_W-1:0]    hi_x;
    logic signed [SUM_W-1:0]    lo_x;
    logic                       gt_hi;
    logic                       lt_lo;
    logic signed [ACC_W-1:0]    res;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= pidpi_pkg::MODE_POS;
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_high_reg <= {1'b0, {(DATA_W-1){1'b1}}};
            limit_low_reg  <= {1'b1, {(DATA_W-1){1'b0}}};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidpi_pkg::REG_MODE:       mode_reg       <= cfg_data[0];
                pidpi_pkg::REG_GAIN_P:     gain_p_reg     <= cfg_data;
                pidpi_pkg::REG_GAIN_I:     gain_i_reg     <= cfg_data;
                pidpi_pkg::REG_GAIN_D:     gain_d_reg     <= cfg_data;
                pidpi_pkg::REG_LIMIT_HIGH: limit_high_reg <= cfg_data;
                pidpi_pkg::REG_LIMIT_LOW:  limit_low_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign out_free = ~out_valid_reg | ~out_stall;
    assign pos_int  = (mode_reg == pidpi_pkg::MODE_POS) && (gain_i_reg != '0);
    assign mul_busy = p_busy | i_busy | d_busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pidpi_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (mode_reg == pidpi_pkg::MODE_INC)
                    begin
                        state_next = pidpi_pkg::ST_LOAD;
                    end
                    else if (gain_i_reg != '0)
                    begin
                        state_next = pidpi_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = pidpi_pkg::ST_INT;
                    end
                end
            end
            pidpi_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = pidpi_pkg::ST_INT;
                end
            end
            pidpi_pkg::ST_INT:
            begin
                state_next = pidpi_pkg::ST_LOAD;
            end
            pidpi_pkg::ST_LOAD:
            begin
                state_next = pidpi_pkg::ST_MUL;
            end
            pidpi_pkg::ST_MUL:
            begin
                if (!mul_busy)
                begin
                    state_next = pidpi_pkg::ST_ADD;
                end
            end
            pidpi_pkg::ST_ADD:
            begin
                if (add_cnt_reg == ADD_LAST)
                begin
                    state_next = pidpi_pkg::ST_CLAMP;
                end
            end
            pidpi_pkg::ST_CLAMP:
            begin
                if (out_free)
                begin
                    state_next = pidpi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pidpi_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        in_stall    = 1'b1;
        take_item   = 1'b0;
        div_start   = 1'b0;
        div_track   = 1'b0;
        int_load    = 1'b0;
        mul_start   = 1'b0;
        sum_init    = 1'b0;
        sum_step    = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            pidpi_pkg::ST_IDLE:
            begin
                in_stall  = 1'b0;
                take_item = in_valid;
                div_start = in_valid & pos_int;
            end
            pidpi_pkg::ST_DIV:
            begin
                div_track = 1'b1;
            end
            pidpi_pkg::ST_INT:
            begin
                int_load = 1'b1;
            end
            pidpi_pkg::ST_LOAD:
            begin
                mul_start = 1'b1;
            end
            pidpi_pkg::ST_MUL:
            begin
                sum_init = ~mul_busy;
            end
            pidpi_pkg::ST_ADD:
            begin
                sum_step = 1'b1;
            end
            pidpi_pkg::ST_CLAMP:
            begin
                result_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pidpi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Error of the incoming sample
    assign e_in = {target[DATA_W-1], target} - {measured[DATA_W-1], measured};

    // Integral limit: |span| << FRAC_BITS over gain_i, sign of span restored
    always_comb
    begin
        span     = {limit_high_reg[DATA_W-1], limit_high_reg}
                 - {limit_low_reg[DATA_W-1], limit_low_reg};
        span_neg = span[DATA_W];
        span_mag = span_neg ? -span : span;
        dividend = {span_mag[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        q_ext    = {{(CMP_W-DVD_W){1'b0}}, quotient};
    end

    pidpi_ser_div #(
        .DVD_W (DVD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (gain_i_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Clip the integral to the limit, then saturate to 32 bits
    always_comb
    begin
        nlmt = -lmt_reg;
        if (isum_reg > lmt_reg)
        begin
            clip = lmt_reg[CMP_W-1] ? nlmt : lmt_reg;
        end
        else if (isum_reg < nlmt)
        begin
            clip = nlmt;
        end
        else
        begin
            clip = isum_reg;
        end
        if (clip > I32_MAX)
        begin
            integ_new = I32_MAX[HIST_W-1:0];
        end
        else if (clip < I32_MIN)
        begin
            integ_new = I32_MIN[HIST_W-1:0];
        end
        else
        begin
            integ_new = clip[HIST_W-1:0];
        end
    end

    // Multiplier operands for the selected form
    always_comb
    begin
        diff_el = {e_reg[ERR_W-1], e_reg} - {last_error_reg[ERR_W-1], last_error_reg};
        d_inc   = {{(D_OP_W-ERR_W){e_reg[ERR_W-1]}}, e_reg}
                - {{(D_OP_W-ERR_W-1){last_error_reg[ERR_W-1]}}, last_error_reg, 1'b0}
                + {hist_reg[HIST_W-1], hist_reg};
        if (mode_reg == pidpi_pkg::MODE_INC)
        begin
            p_op = diff_el;
            i_op = {{(I_OP_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
            d_op = d_inc;
        end
        else
        begin
            p_op = {e_reg[ERR_W-1], e_reg};
            i_op = hist_reg;
            d_op = {{(D_OP_W-P_OP_W){diff_el[P_OP_W-1]}}, diff_el};
        end
    end

    pidpi_ser_mul #(
        .A_W (P_OP_W)
    ) u_mul_p (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (p_op),
        .b       (gain_p_reg),
        .busy    (p_busy),
        .product (p_prod)
    );

    pidpi_ser_mul #(
        .A_W (I_OP_W)
    ) u_mul_i (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (i_op),
        .b       (gain_i_reg),
        .busy    (i_busy),
        .product (i_prod)
    );

    pidpi_ser_mul #(
        .A_W (D_OP_W)
    ) u_mul_d (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (d_op),
        .b       (gain_d_reg),
        .busy    (d_busy),
        .product (d_prod)
    );

    // Pick one product per cycle for the accumulating adder
    always_comb
    begin
        unique case (add_cnt_reg)
            2'd0:    add_term = {{(SUM_W-P_OP_W-GAIN_W){p_prod[P_OP_W+GAIN_W-1]}}, p_prod};
            2'd1:    add_term = {{(SUM_W-I_OP_W-GAIN_W){i_prod[I_OP_W+GAIN_W-1]}}, i_prod};
            2'd2:    add_term = {{(SUM_W-D_OP_W-GAIN_W){d_prod[D_OP_W+GAIN_W-1]}}, d_prod};
            default: add_term = '0;
        endcase
        if (mode_reg == pidpi_pkg::MODE_INC)
        begin
            sum_base = {{(SUM_W-ACC_W){accum_reg[ACC_W-1]}}, accum_reg};
        end
        else
        begin
            sum_base = '0;
        end
    end

    // Clamp the raw value; an inverted pair of limits ends at the lower one
    always_comb
    begin
        hi_s  = {limit_high_reg, {FRAC_BITS{1'b0}}};
        lo_s  = {limit_low_reg, {FRAC_BITS{1'b0}}};
        hi_x  = {{(SUM_W-ACC_W){hi_s[ACC_W-1]}}, hi_s};
        lo_x  = {{(SUM_W-ACC_W){lo_s[ACC_W-1]}}, lo_s};
        gt_hi = (sum_reg > hi_x);
        lt_lo = (sum_reg < lo_x);
        if (gt_hi)
        begin
            res = (limit_high_reg < limit_low_reg) ? lo_s : hi_s;
        end
        else if (lt_lo)
        begin
            res = lo_s;
        end
        else
        begin
            res = sum_reg[ACC_W-1:0];
        end
    end

    // Controller state: error history, integral and stored output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            hist_reg       <= '0;
            accum_reg      <= '0;
        end
        else
        begin
            if (int_load)
            begin
                hist_reg <= (gain_i_reg == '0) ? '0 : integ_new;
            end
            else if (result_load && (mode_reg == pidpi_pkg::MODE_INC))
            begin
                hist_reg <= {{(HIST_W-ERR_W){last_error_reg[ERR_W-1]}}, last_error_reg};
            end
            if (result_load)
            begin
                last_error_reg <= e_reg;
                accum_reg      <= res;
            end
        end
    end

    // Working registers of one transaction
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            e_reg <= e_in;
        end
        if (div_track)
        begin
            isum_reg <= {{(CMP_W-HIST_W){hist_reg[HIST_W-1]}}, hist_reg}
                      + {{(CMP_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
            lmt_reg  <= span_neg ? -q_ext : q_ext;
        end
        if (sum_init)
        begin
            sum_reg <= sum_base;
        end
        else if (sum_step)
        begin
            sum_reg <= sum_reg + add_term;
        end
    end

    // Adder step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_cnt_reg <= '0;
        end
        else if (sum_init)
        begin
            add_cnt_reg <= '0;
        end
        else if (sum_step)
        begin
            add_cnt_reg <= add_cnt_reg + 2'd1;
        end
    end

    // Output register: hold under stall, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            drive_reg   <= res[ACC_W-1:FRAC_BITS];
            clamped_reg <= gt_hi | lt_lo;
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign clamped   = clamped_reg;

endmodule
